/* src/rlp_pkg.sv */
// rlp_pkg: shared widths, phase codes, register indexes and item structs
// for the range list text parser; used by rlp_step and the top level.
// no dependencies.
package rlp_pkg;

  // bitmap size the parser is built for
  localparam int MAX_BITS = 4096;

  localparam int CHAR_W  = 8;
  localparam int BOUND_W = 12;
  localparam int COUNT_W = 13;
  localparam int VAL_W   = (MAX_BITS > 2) ? $clog2(MAX_BITS) : 1;
  // wide enough for value * 10 + 9 and for either limit
  localparam int CMP_W   = (VAL_W + 4 > COUNT_W + 1) ? VAL_W + 4 : COUNT_W + 1;

  localparam int RADIX = 10;

  localparam logic [CHAR_W-1:0] NUL_CODE   = 8'h00;
  localparam logic [CHAR_W-1:0] ZERO_CODE  = 8'h30;
  localparam logic [CHAR_W-1:0] NINE_CODE  = 8'h39;
  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
  localparam logic [CHAR_W-1:0] TAB_CODE   = 8'h09;
  localparam logic [CHAR_W-1:0] CR_CODE    = 8'h0D;

  // parser phases
  localparam logic [2:0] PH_FIRST       = 3'd0;
  localparam logic [2:0] PH_NEXT        = 3'd1;
  localparam logic [2:0] PH_AFTER_ENUM  = 3'd2;
  localparam logic [2:0] PH_AFTER_RANGE = 3'd3;
  localparam logic [2:0] PH_AWAIT       = 3'd4;
  localparam logic [2:0] PH_DISCARD     = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_LIST_SEP  = 2'd0;
  localparam logic [1:0] REG_SPAN_SEP  = 2'd1;
  localparam logic [1:0] REG_BIT_COUNT = 2'd2;

  localparam logic [CHAR_W-1:0]  LIST_SEP_RST  = 8'd44;
  localparam logic [CHAR_W-1:0]  SPAN_SEP_RST  = 8'd45;
  localparam logic [COUNT_W-1:0] BIT_COUNT_RST = 13'd4096;

  typedef struct packed {
    logic [2:0]       phase;
    logic [VAL_W-1:0] begin_value;
    logic [VAL_W-1:0] end_value;
    logic             filling_end;
  } state_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  list_sep;
    logic [CHAR_W-1:0]  span_sep;
    logic [COUNT_W-1:0] bit_count;
  } cfg_t;

  typedef struct packed {
    logic               range_valid;
    logic [BOUND_W-1:0] range_begin;
    logic [BOUND_W-1:0] range_end;
    logic               string_done;
    logic               parse_error;
  } result_t;

  // low bound bits of a value, zero extended where the value is narrower
  function automatic logic [BOUND_W-1:0] to_bound(input logic [VAL_W-1:0] v);
    logic [VAL_W+BOUND_W-1:0] w;
    w = (VAL_W + BOUND_W)'(v);
    return w[BOUND_W-1:0];
  endfunction

endpackage

/* src/range_list_text_parser_core.sv */
// range_list_text_parser_core: top level of the range list text parser.
// depends on rlp_pkg and rlp_step.
//
// Takes one character per item and can accept a new character every clock
// cycle while char_stall is low. Each character is parsed in the cycle it is
// accepted; its result, if any, goes to the result register, or to a one-entry
// skid buffer behind it when a result waits untaken, so char_stall is a
// registered signal that rises only once two results are waiting; the
// sustained rate is one character per cycle while results are taken. A result
// carries either a finished range, a string done flag, or both; characters
// that finish nothing produce no result. After an error all characters up to
// and including the next NUL are dropped silently. Configuration registers
// sit at byte addresses 0 (list separator), 4 (range joiner) and 8 (bit count)
// and must only be written while the parser is idle.
module range_list_text_parser_core (
  input  logic                           clk,
  input  logic                           rst,
  // character channel
  input  logic                           char_valid,
  output logic                           char_stall,
  input  logic [rlp_pkg::CHAR_W-1:0]     char_code,
  // result channel
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic                           range_valid,
  output logic [rlp_pkg::BOUND_W-1:0]    range_begin,
  output logic [rlp_pkg::BOUND_W-1:0]    range_end,
  output logic                           string_done,
  output logic                           parse_error,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import rlp_pkg::*;

  state_t  st;
  state_t  st_next;
  cfg_t    cfg;
  logic    has_result;
  result_t step_res;
  result_t out_res;
  result_t skid;
  logic    skid_valid;
  logic    accept;
  logic    out_take;
  logic    cfg_write;
  logic [1:0] reg_index;

  assign accept     = char_valid && !char_stall;
  assign out_take   = result_valid && !result_stall;
  assign char_stall = skid_valid;

  // character step
  rlp_step u_step (
    .st         (st),
    .cfg        (cfg),
    .char_code  (char_code),
    .st_next    (st_next),
    .has_result (has_result),
    .res        (step_res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= {PH_FIRST, {(2 * VAL_W + 1){1'b0}}};
    end else if (accept) begin
      st <= st_next;
    end
  end

  // configuration registers
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.list_sep  <= LIST_SEP_RST;
      cfg.span_sep  <= SPAN_SEP_RST;
      cfg.bit_count <= BIT_COUNT_RST;
    end else if (cfg_write) begin
      case (reg_index)
        REG_LIST_SEP:  cfg.list_sep  <= pwdata[CHAR_W-1:0];
        REG_SPAN_SEP:  cfg.span_sep  <= pwdata[CHAR_W-1:0];
        REG_BIT_COUNT: cfg.bit_count <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_index)
      REG_LIST_SEP:  prdata = 32'(cfg.list_sep);
      REG_SPAN_SEP:  prdata = 32'(cfg.span_sep);
      REG_BIT_COUNT: prdata = 32'(cfg.bit_count);
      default:       prdata = '0;
    endcase
  end

  // result register and skid buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept && has_result) begin
      if (result_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (out_take) begin
      result_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_res <= skid;
      end
    end else if (accept && has_result) begin
      if (result_valid && !out_take) begin
        skid <= step_res;
      end else begin
        out_res <= step_res;
      end
    end
  end

  assign range_valid = out_res.range_valid;
  assign range_begin = out_res.range_begin;
  assign range_end   = out_res.range_end;
  assign string_done = out_res.string_done;
  assign parse_error = out_res.parse_error;

  // every result finishes a range or a string
  a_result_content: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (range_valid || string_done))
    else $error("result with neither range nor done");

  // an error ends the string and carries no range
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (result_valid && parse_error) |-> (string_done && !range_valid))
    else $error("error result malformed");

  // skid only fills behind a waiting result
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds an item while result register is empty");

  // a terminator always restarts the parser
  a_nul_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && (char_code == NUL_CODE)) |=> (st.phase == PH_FIRST))
    else $error("parser not restarted after terminator");

endmodule

/* src/rlp_step.sv */
// rlp_step: one character step of the range list parser, combinational.
// depends on rlp_pkg for state, configuration and result structs.
module rlp_step (
  input  rlp_pkg::state_t             st,
  input  rlp_pkg::cfg_t               cfg,
  input  logic [rlp_pkg::CHAR_W-1:0]  char_code,
  output rlp_pkg::state_t             st_next,
  output logic                        has_result,
  output rlp_pkg::result_t            res
);
  import rlp_pkg::*;

  logic             is_nul;
  logic             is_enum;
  logic             is_range;
  logic             is_digit;
  logic             is_space;
  logic             fresh;
  logic             fill_end;
  logic [VAL_W-1:0] cur_val;
  logic [3:0]       digit;
  logic [CMP_W-1:0] num;
  logic             too_big;
  logic [VAL_W-1:0] new_val;
  logic [VAL_W-1:0] closed_end;
  state_t           start_st;
  result_t          fail_res;
  result_t          done_res;

  // character classes; a marker never matches the terminator
  always_comb begin
    is_nul   = (char_code == NUL_CODE);
    is_enum  = !is_nul && (char_code == cfg.list_sep);
    is_range = !is_nul && (char_code == cfg.span_sep);
    is_digit = (char_code >= ZERO_CODE) && (char_code <= NINE_CODE);
    is_space = (char_code == SPACE_CODE) ||
               ((char_code >= TAB_CODE) && (char_code <= CR_CODE));
  end

  // digit accumulation into the bound being filled
  always_comb begin
    logic [CHAR_W-1:0] d8;
    d8       = char_code - ZERO_CODE;
    digit    = d8[3:0];
    fresh    = (st.phase == PH_FIRST) || (st.phase == PH_AFTER_ENUM) ||
               (st.phase == PH_AFTER_RANGE);
    fill_end = fresh ? (st.phase == PH_AFTER_RANGE) : st.filling_end;
    cur_val  = fill_end ? st.end_value : st.begin_value;
    if (fresh) begin
      num = CMP_W'(digit);
    end else begin
      num = CMP_W'(cur_val) * CMP_W'(RADIX) + CMP_W'(digit);
    end
    too_big = (num >= CMP_W'(cfg.bit_count)) || (num >= CMP_W'(MAX_BITS));
    new_val = num[VAL_W-1:0];
    closed_end = st.filling_end ? st.end_value : st.begin_value;
  end

  // fixed results and the fresh-string state
  always_comb begin
    start_st             = '0;
    start_st.phase       = PH_FIRST;
    fail_res             = '0;
    fail_res.string_done = 1'b1;
    fail_res.parse_error = 1'b1;
    done_res             = '0;
    done_res.string_done = 1'b1;
  end

  // phase transitions
  always_comb begin
    st_next    = st;
    has_result = 1'b0;
    res        = '0;
    case (st.phase)
      PH_FIRST, PH_AFTER_ENUM, PH_AFTER_RANGE: begin
        if (is_nul) begin
          st_next    = start_st;
          has_result = 1'b1;
          res        = done_res;
        end else if (is_enum || is_range) begin
          st_next       = start_st;
          st_next.phase = PH_DISCARD;
          has_result    = 1'b1;
          res           = fail_res;
        end else if (is_digit) begin
          if (too_big) begin
            st_next       = start_st;
            st_next.phase = PH_DISCARD;
            has_result    = 1'b1;
            res           = fail_res;
          end else begin
            st_next.filling_end = fill_end;
            st_next.phase       = PH_NEXT;
            if (fill_end) begin
              st_next.end_value = new_val;
            end else begin
              st_next.begin_value = new_val;
            end
          end
        end else if (!is_space) begin
          st_next       = start_st;
          st_next.phase = PH_DISCARD;
          has_result    = 1'b1;
          res           = fail_res;
        end
      end
      PH_NEXT, PH_AWAIT: begin
        if (is_nul) begin
          st_next         = start_st;
          has_result      = 1'b1;
          res.range_valid = 1'b1;
          res.range_begin = to_bound(st.begin_value);
          res.range_end   = to_bound(closed_end);
          res.string_done = 1'b1;
        end else if (is_enum) begin
          st_next.end_value = closed_end;
          st_next.phase     = PH_AFTER_ENUM;
          has_result        = 1'b1;
          res.range_valid   = 1'b1;
          res.range_begin   = to_bound(st.begin_value);
          res.range_end     = to_bound(closed_end);
        end else if (is_range) begin
          st_next.phase = PH_AFTER_RANGE;
        end else if (is_digit) begin
          if ((st.phase == PH_AWAIT) || too_big) begin
            st_next       = start_st;
            st_next.phase = PH_DISCARD;
            has_result    = 1'b1;
            res           = fail_res;
          end else if (fill_end) begin
            st_next.end_value = new_val;
          end else begin
            st_next.begin_value = new_val;
          end
        end else if (is_space) begin
          st_next.phase = PH_AWAIT;
        end else begin
          st_next       = start_st;
          st_next.phase = PH_DISCARD;
          has_result    = 1'b1;
          res           = fail_res;
        end
      end
      default: begin
        // discarding through the next terminator
        if (is_nul) begin
          st_next = start_st;
        end
      end
    endcase
  end

endmodule
